// ----- rtl/core/mrse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_pkg
// Shared types, constants and the CRC byte step of the Modbus RTU slave engine.
// ----------------------------------------------------------------------------
package mrse_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int BUF_AW = $clog2(BUFFER_BYTES);
    localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] FN_READ = 8'h03;
    localparam logic [7:0] FN_WRITE = 8'h06;
    localparam logic [7:0] EXC_FLAG = 8'h80;
    localparam logic [7:0] EXC_FUNCTION = 8'h01;
    localparam logic [7:0] EXC_ADDRESS = 8'h02;
    localparam logic [7:0] EXC_VALUE = 8'h03;
    localparam logic [7:0] PORT_RESET = 8'hFF;
    localparam logic [7:0] ADDR_RESET = 8'h20;
    localparam logic [7:0] GAP_RESET = 8'd216;
    localparam logic [15:0] REGNUM_RESET = 16'd1;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_GAP_TICKS = 2'd1;
    localparam logic [1:0] CFG_REGISTER_NUMBER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RCRC,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [7:0] pins;
    } job_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic last_byte;
        logic [7:0] port_value;
    } out_item_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        c = crc_in ^ {8'h00, d};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mrse_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_front
// Receive side: frame buffer, byte count and inter-frame gap timer.
// ----------------------------------------------------------------------------
module mrse_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire logic action,
    input  wire logic [7:0] rx_byte,
    input  wire logic framing_error,
    input  wire logic [7:0] pin_state,
    input  wire logic [7:0] gap_ticks,
    input  wire logic [mrse_pkg::BUF_AW-1:0] rd_addr,
    output logic [7:0] rd_data,
    output logic job_push,
    output mrse_pkg::job_t job
);

    logic [7:0] mem [mrse_pkg::BUFFER_BYTES];
    logic receiving_reg, receiving_next;
    logic [mrse_pkg::LEN_W-1:0] length_reg, length_next;
    logic [7:0] gap_reg, gap_next;
    logic wr_en;
    logic [mrse_pkg::BUF_AW-1:0] wr_addr;
    logic [mrse_pkg::LEN_W-1:0] base;
    logic [7:0] g;

    always_comb
    begin
        receiving_next = receiving_reg;
        length_next = length_reg;
        gap_next = gap_reg;
        wr_en = 1'b0;
        wr_addr = '0;
        job_push = 1'b0;
        base = receiving_reg ? length_reg : '0;
        g = (gap_reg == 8'hFF) ? gap_reg : gap_reg + 8'd1;
        job.length = length_reg;
        job.pins = pin_state;
        if (accept)
        begin
            if (!action)
            begin
                if (!framing_error)
                begin
                    receiving_next = 1'b1;
                    gap_next = '0;
                    wr_en = 1'b1;
                    if (base < mrse_pkg::LEN_W'(mrse_pkg::BUFFER_BYTES))
                    begin
                        wr_addr = base[mrse_pkg::BUF_AW-1:0];
                        length_next = base + 1'b1;
                    end
                    else
                    begin
                        wr_addr = mrse_pkg::BUF_AW'(mrse_pkg::BUFFER_BYTES - 1);
                        length_next = base;
                    end
                end
            end
            else if (receiving_reg)
            begin
                if (g >= gap_ticks)
                begin
                    receiving_next = 1'b0;
                    gap_next = '0;
                    job_push = 1'b1;
                end
                else
                begin
                    gap_next = g;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            length_reg <= '0;
            gap_reg <= '0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            length_reg <= length_next;
            gap_reg <= gap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= rx_byte;
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/mrse_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_out_fifo
// Queue of reply bytes waiting to be taken by the transmitter.
// ----------------------------------------------------------------------------
module mrse_out_fifo (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  mrse_pkg::out_item_t wr_item,
    input  wire logic rd_en,
    output mrse_pkg::out_item_t rd_item,
    output logic empty,
    output logic [mrse_pkg::OUT_CW-1:0] count
);

    localparam int AW = $clog2(mrse_pkg::OUT_DEPTH);

    mrse_pkg::out_item_t mem [mrse_pkg::OUT_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [mrse_pkg::OUT_CW-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rd_item = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_item;
    end

endmodule
`default_nettype wire

// ----- rtl/core/mrse_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mrse_back
// Frame checker and reply builder, fed through a one-entry job queue.
// ----------------------------------------------------------------------------
module mrse_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_push,
    input  mrse_pkg::job_t job,
    input  wire logic [7:0] slave_address,
    input  wire logic [15:0] register_number,
    input  wire logic fifo_empty,
    output logic [mrse_pkg::BUF_AW-1:0] rd_addr,
    input  wire logic [7:0] rd_data,
    output logic busy,
    output logic out_push,
    output mrse_pkg::out_item_t out_item
);

    localparam int LW = mrse_pkg::LEN_W;

    mrse_pkg::back_state_t state_reg, state_next;
    logic job_valid_reg, job_valid_next;
    mrse_pkg::job_t job_reg;
    logic [LW-1:0] n_reg, n_next;
    logic [7:0] pins_reg, pins_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic pv_reg, pv_next;
    logic [LW-1:0] pidx_reg, pidx_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] got_reg, got_next;
    logic [7:0] hdr_reg [8];
    logic [7:0] hdr_next [8];
    logic [7:0] r_reg [8];
    logic [7:0] r_next [8];
    logic [3:0] rlen_reg, rlen_next;
    logic [3:0] ccount_reg, ccount_next;
    logic [3:0] k_reg, k_next;
    logic [7:0] port_reg, port_next;
    logic [15:0] addr_f, val_f;

    assign busy = job_valid_reg || (state_reg != mrse_pkg::ST_IDLE);
    assign addr_f = {hdr_reg[2], hdr_reg[3]};
    assign val_f = {hdr_reg[4], hdr_reg[5]};

    always_comb
    begin
        state_next = state_reg;
        job_valid_next = job_valid_reg;
        n_next = n_reg;
        pins_next = pins_reg;
        cnt_next = cnt_reg;
        pv_next = 1'b0;
        pidx_next = pidx_reg;
        crc_next = crc_reg;
        got_next = got_reg;
        hdr_next = hdr_reg;
        r_next = r_reg;
        rlen_next = rlen_reg;
        ccount_next = ccount_reg;
        k_next = k_reg;
        port_next = port_reg;
        rd_addr = cnt_reg[mrse_pkg::BUF_AW-1:0];
        out_push = 1'b0;
        out_item.tx_byte = r_reg[k_reg[2:0]];
        out_item.last_byte = (k_reg == rlen_reg - 4'd1);
        out_item.port_value = port_reg;
        if (job_push)
            job_valid_next = 1'b1;
        case (state_reg)
            mrse_pkg::ST_IDLE:
            begin
                if (job_valid_reg && fifo_empty)
                begin
                    job_valid_next = 1'b0;
                    if (job_reg.length >= LW'(4))
                    begin
                        n_next = job_reg.length;
                        pins_next = job_reg.pins;
                        cnt_next = '0;
                        crc_next = mrse_pkg::CRC_INIT;
                        for (int i = 0; i < 8; i++)
                            hdr_next[i] = '0;
                        state_next = mrse_pkg::ST_READ;
                    end
                end
            end
            mrse_pkg::ST_READ:
            begin
                if (cnt_reg < n_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next = 1'b1;
                    pidx_next = cnt_reg;
                end
                if (pv_reg)
                begin
                    if (pidx_reg < n_reg - LW'(2))
                        crc_next = mrse_pkg::crc_byte(crc_reg, rd_data);
                    if (pidx_reg < LW'(8))
                        hdr_next[pidx_reg[2:0]] = rd_data;
                    if (pidx_reg == n_reg - LW'(2))
                        got_next[7:0] = rd_data;
                    if (pidx_reg == n_reg - LW'(1))
                        got_next[15:8] = rd_data;
                end
                if (cnt_reg == n_reg && !pv_reg)
                    state_next = mrse_pkg::ST_CHECK;
            end
            mrse_pkg::ST_CHECK:
            begin
                k_next = '0;
                crc_next = mrse_pkg::CRC_INIT;
                r_next[0] = slave_address;
                r_next[1] = hdr_reg[1] + mrse_pkg::EXC_FLAG;
                rlen_next = 4'd5;
                ccount_next = 4'd3;
                state_next = mrse_pkg::ST_RCRC;
                if (hdr_reg[0] != slave_address || crc_reg != got_reg)
                begin
                    state_next = mrse_pkg::ST_IDLE;
                end
                else
                begin
                    case (hdr_reg[1])
                        mrse_pkg::FN_READ:
                        begin
                            if (addr_f != register_number || val_f != 16'd1)
                            begin
                                r_next[2] = mrse_pkg::EXC_ADDRESS;
                            end
                            else
                            begin
                                r_next[1] = mrse_pkg::FN_READ;
                                r_next[2] = 8'h02;
                                r_next[3] = 8'h00;
                                r_next[4] = pins_reg;
                                rlen_next = 4'd7;
                                ccount_next = 4'd5;
                            end
                        end
                        mrse_pkg::FN_WRITE:
                        begin
                            if (addr_f != register_number)
                                r_next[2] = mrse_pkg::EXC_ADDRESS;
                            else if (val_f > 16'h00FF)
                                r_next[2] = mrse_pkg::EXC_VALUE;
                            else
                            begin
                                port_next = val_f[7:0];
                                r_next = hdr_reg;
                                rlen_next = 4'd8;
                                state_next = mrse_pkg::ST_EMIT;
                            end
                        end
                        default:
                        begin
                            r_next[2] = mrse_pkg::EXC_FUNCTION;
                        end
                    endcase
                end
            end
            mrse_pkg::ST_RCRC:
            begin
                if (k_reg < ccount_reg)
                begin
                    crc_next = mrse_pkg::crc_byte(crc_reg, r_reg[k_reg[2:0]]);
                    k_next = k_reg + 4'd1;
                end
                else
                begin
                    r_next[ccount_reg[2:0]] = crc_reg[7:0];
                    r_next[ccount_reg[2:0] + 3'd1] = crc_reg[15:8];
                    k_next = '0;
                    state_next = mrse_pkg::ST_EMIT;
                end
            end
            mrse_pkg::ST_EMIT:
            begin
                out_push = 1'b1;
                k_next = k_reg + 4'd1;
                if (k_reg == rlen_reg - 4'd1)
                    state_next = mrse_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mrse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrse_pkg::ST_IDLE;
            job_valid_reg <= 1'b0;
            cnt_reg <= '0;
            pv_reg <= 1'b0;
            k_reg <= '0;
            port_reg <= mrse_pkg::PORT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            job_valid_reg <= job_valid_next;
            cnt_reg <= cnt_next;
            pv_reg <= pv_next;
            k_reg <= k_next;
            port_reg <= port_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_push)
            job_reg <= job;
        n_reg <= n_next;
        pins_reg <= pins_next;
        pidx_reg <= pidx_next;
        crc_reg <= crc_next;
        got_reg <= got_next;
        hdr_reg <= hdr_next;
        r_reg <= r_next;
        rlen_reg <= rlen_next;
        ccount_reg <= ccount_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/modbus_rtu_slave_frame_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine
// Modbus RTU slave: collects received bytes, ends frames on an idle gap and
// queues the reply bytes.
// ----------------------------------------------------------------------------
// Each input item is a received byte or a timer tick, offered with push and
// taken when full is low. The tick that ends a frame hands it to the back
// part, which reads the frame buffer one byte a cycle through its registered
// port, checks address and CRC, builds the reply and, but for a write echo,
// computes its CRC one byte a cycle. A frame keeps full high until the back
// part is done with it, plus the time the result queue needs to drain, since
// a reply starts only into an empty queue. Reply bytes appear as result
// items while empty is low and leave on pop; a stalled receiver only holds
// the queue, and a new frame then waits.
// Configuration is written through cfg_write, cfg_index and cfg_data.
// Reset empties both queues, clears the receiver and sets the output port to
// all ones and the registers to their default values.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_frame_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire logic action,
    input  wire logic [7:0] rx_byte,
    input  wire logic framing_error,
    input  wire logic [7:0] pin_state,
    output logic empty,
    input  wire logic pop,
    output logic [7:0] tx_byte,
    output logic last_byte,
    output logic [7:0] port_value,
    input  wire logic cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [7:0] slave_address_reg;
    logic [7:0] gap_ticks_reg;
    logic [15:0] register_number_reg;
    logic accept, job_push, busy, res_push;
    mrse_pkg::job_t job;
    logic [mrse_pkg::BUF_AW-1:0] rd_addr;
    logic [7:0] rd_data;
    mrse_pkg::out_item_t res_in, res_out;
    logic [mrse_pkg::OUT_CW-1:0] res_count;

    assign full = busy;
    assign accept = push && !full;
    assign tx_byte = res_out.tx_byte;
    assign last_byte = res_out.last_byte;
    assign port_value = res_out.port_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= mrse_pkg::ADDR_RESET;
            gap_ticks_reg <= mrse_pkg::GAP_RESET;
            register_number_reg <= mrse_pkg::REGNUM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mrse_pkg::CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_data[7:0];
                mrse_pkg::CFG_GAP_TICKS: gap_ticks_reg <= cfg_data[7:0];
                mrse_pkg::CFG_REGISTER_NUMBER: register_number_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    mrse_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .action(action),
        .rx_byte(rx_byte),
        .framing_error(framing_error),
        .pin_state(pin_state),
        .gap_ticks(gap_ticks_reg),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .job_push(job_push),
        .job(job)
    );

    mrse_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job_push(job_push),
        .job(job),
        .slave_address(slave_address_reg),
        .register_number(register_number_reg),
        .fifo_empty(empty),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .busy(busy),
        .out_push(res_push),
        .out_item(res_in)
    );

    mrse_out_fifo u_out (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(res_push),
        .wr_item(res_in),
        .rd_en(pop && !empty),
        .rd_item(res_out),
        .empty(empty),
        .count(res_count)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && !(pop && !empty) && res_count == mrse_pkg::OUT_CW'(mrse_pkg::OUT_DEPTH)))
        else $error("Result queue overflow.");
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> busy)
        else $error("Result item written while the back part is idle.");
    a_job_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |=> full)
        else $error("Input taken while a frame is pending.");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_modbus_rtu_slave_frame_engine.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU slave frame engine testbench
// Drives received bytes and timer ticks as items, predicts every reply byte
// from a behavioural model of the slave and checks each result in order.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_slave_frame_engine;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic       framing_error;
        logic [7:0] pin_state;
    } rx_item_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic action;
    logic [7:0] rx_byte;
    logic framing_error;
    logic [7:0] pin_state;
    logic empty;
    logic pop;
    logic [7:0] tx_byte;
    logic last_byte;
    logic [7:0] port_value;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    modbus_rtu_slave_frame_engine uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .rx_byte(rx_byte), .framing_error(framing_error), .pin_state(pin_state),
        .empty(empty), .pop(pop), .tx_byte(tx_byte), .last_byte(last_byte),
        .port_value(port_value), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    rx_item_t pending_items[$];
    mrse_pkg::out_item_t reply_bytes[$];

    logic [7:0] frame_mem[mrse_pkg::BUFFER_BYTES];
    int unsigned frame_len;
    bit rx_active;
    logic [7:0] idle_ticks;
    logic [7:0] port_reg;
    logic [7:0] station_addr;
    logic [7:0] end_ticks;
    logic [15:0] served_reg;

    int send_idle_pct;
    int take_idle_pct;
    int failures;
    int unsigned cycles;
    int unsigned accepted;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] frame_byte(int unsigned pos);
        if (pos < frame_len && pos < mrse_pkg::BUFFER_BYTES)
            return frame_mem[pos];
        return 8'h00;
    endfunction

    function automatic logic [15:0] crc_of(logic [7:0] bytes[$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (bytes[i])
            c = crc_step(c, bytes[i]);
        return c;
    endfunction

    task automatic queue_reply(logic [7:0] bytes[$]);
        mrse_pkg::out_item_t o;
        foreach (bytes[i])
        begin
            o.tx_byte = bytes[i];
            o.last_byte = (i == bytes.size() - 1);
            o.port_value = port_reg;
            reply_bytes.push_back(o);
        end
    endtask

    task automatic queue_exception(logic [7:0] code);
        logic [7:0] r[$];
        logic [15:0] c;
        r = '{station_addr, frame_byte(1) + mrse_pkg::EXC_FLAG, code};
        c = crc_of(r);
        r.push_back(c[7:0]);
        r.push_back(c[15:8]);
        queue_reply(r);
    endtask

    task automatic answer_frame(logic [7:0] pins);
        logic [7:0] body[$];
        logic [7:0] r[$];
        logic [15:0] c;
        logic [15:0] reg_addr;
        logic [15:0] reg_val;
        if (frame_len < 4)
            return;
        if (frame_byte(0) != station_addr)
            return;
        for (int i = 0; i < frame_len - 2; i++)
            body.push_back(frame_mem[i]);
        if (crc_of(body) != {frame_byte(frame_len - 1), frame_byte(frame_len - 2)})
            return;
        reg_addr = {frame_byte(2), frame_byte(3)};
        reg_val = {frame_byte(4), frame_byte(5)};
        if (frame_byte(1) == mrse_pkg::FN_READ)
        begin
            if (reg_addr != served_reg || reg_val != 16'd1)
            begin
                queue_exception(mrse_pkg::EXC_ADDRESS);
                return;
            end
            r = '{station_addr, mrse_pkg::FN_READ, 8'h02, 8'h00, pins};
            c = crc_of(r);
            r.push_back(c[7:0]);
            r.push_back(c[15:8]);
            queue_reply(r);
        end
        else if (frame_byte(1) == mrse_pkg::FN_WRITE)
        begin
            if (reg_addr != served_reg)
                queue_exception(mrse_pkg::EXC_ADDRESS);
            else if (reg_val > 16'h00FF)
                queue_exception(mrse_pkg::EXC_VALUE);
            else
            begin
                port_reg = reg_val[7:0];
                for (int i = 0; i < 8; i++)
                    r.push_back(frame_byte(i));
                queue_reply(r);
            end
        end
        else
            queue_exception(mrse_pkg::EXC_FUNCTION);
    endtask

    task automatic predict_item(rx_item_t it);
        if (!it.action)
        begin
            if (it.framing_error)
                return;
            if (!rx_active)
            begin
                rx_active = 1'b1;
                frame_len = 0;
            end
            if (frame_len < mrse_pkg::BUFFER_BYTES)
            begin
                frame_mem[frame_len] = it.rx_byte;
                frame_len++;
            end
            else
                frame_mem[mrse_pkg::BUFFER_BYTES-1] = it.rx_byte;
            idle_ticks = 8'd0;
            return;
        end
        if (!rx_active)
            return;
        if (idle_ticks != 8'hFF)
            idle_ticks++;
        if (idle_ticks < end_ticks)
            return;
        rx_active = 1'b0;
        idle_ticks = 8'd0;
        answer_frame(it.pin_state);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_item('{action, rx_byte, framing_error, pin_state});
            accepted++;
        end
        if (!rst_n || !push || !full)
        begin
            if (pending_items.size() > 0 && rst_n && $urandom_range(99) >= send_idle_pct)
            begin
                rx_item_t n;
                n = pending_items.pop_front();
                push <= 1'b1;
                action <= n.action;
                rx_byte <= n.rx_byte;
                framing_error <= n.framing_error;
                pin_state <= n.pin_state;
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && pop && !empty)
        begin
            if (reply_bytes.size() == 0)
            begin
                $error("unexpected result tx_byte %h", tx_byte);
                failures++;
            end
            else
            begin
                mrse_pkg::out_item_t e;
                e = reply_bytes.pop_front();
                if (tx_byte !== e.tx_byte)
                begin
                    $error("tx_byte expected %h actual %h", e.tx_byte, tx_byte);
                    failures++;
                end
                if (last_byte !== e.last_byte)
                begin
                    $error("last_byte expected %b actual %b", e.last_byte, last_byte);
                    failures++;
                end
                if (port_value !== e.port_value)
                begin
                    $error("port_value expected %h actual %h", e.port_value, port_value);
                    failures++;
                end
            end
        end
        pop <= ($urandom_range(99) >= take_idle_pct);
    end

    int unsigned sent;

    task automatic add_item(logic act, logic [7:0] b, logic fe, logic [7:0] pins);
        pending_items.push_back('{act, b, fe, pins});
        sent++;
    endtask

    task automatic add_frame(logic [7:0] bytes[$], bit good_crc, int gap);
        logic [15:0] c;
        c = crc_of(bytes);
        foreach (bytes[i])
            add_item(1'b0, bytes[i], 1'b0, 8'($urandom));
        if (good_crc)
        begin
            add_item(1'b0, c[7:0], 1'b0, 8'($urandom));
            add_item(1'b0, c[15:8], 1'b0, 8'($urandom));
        end
        for (int i = 0; i < gap; i++)
            add_item(1'b1, 8'($urandom), 1'($urandom_range(1)), 8'($urandom));
    endtask

    task automatic drain;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (push || reply_bytes.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == mrse_pkg::CFG_SLAVE_ADDRESS)
            station_addr = val[7:0];
        else if (idx == mrse_pkg::CFG_GAP_TICKS)
            end_ticks = val[7:0];
        else
            served_reg = val;
    endtask

    task automatic random_frame;
        logic [7:0] f[$];
        int kind;
        int len;
        kind = $urandom_range(9);
        f.push_back(($urandom_range(7) == 0) ? 8'($urandom) : station_addr);
        case ($urandom_range(3))
            0: f.push_back(mrse_pkg::FN_READ);
            1, 2: f.push_back(mrse_pkg::FN_WRITE);
            default: f.push_back(8'($urandom));
        endcase
        if ($urandom_range(3) == 0)
            f.push_back(8'($urandom));
        else
            f.push_back(served_reg[15:8]);
        if ($urandom_range(3) == 0)
            f.push_back(8'($urandom));
        else
            f.push_back(served_reg[7:0]);
        if (f[1] == mrse_pkg::FN_READ && $urandom_range(3) != 0)
        begin
            f.push_back(8'h00);
            f.push_back(8'h01);
        end
        else
        begin
            f.push_back(($urandom_range(2) == 0) ? 8'($urandom) : 8'h00);
            f.push_back(8'($urandom));
        end
        len = (kind == 0) ? $urandom_range(0, 4) : 6;
        while (f.size() > len)
            void'(f.pop_back());
        if (kind == 1)
            add_item(1'b0, 8'($urandom), 1'b1, 8'($urandom));
        add_frame(f, kind != 2, end_ticks + $urandom_range(2));
    endtask

    initial
    begin
        logic [7:0] f[$];
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        action = 1'b0;
        rx_byte = 8'h00;
        framing_error = 1'b0;
        pin_state = 8'h00;
        cfg_write = 1'b0;
        cfg_index = mrse_pkg::CFG_SLAVE_ADDRESS;
        cfg_data = 16'h0000;
        failures = 0;
        cycles = 0;
        accepted = 0;
        sent = 0;
        frame_len = 0;
        rx_active = 1'b0;
        idle_ticks = 8'd0;
        port_reg = mrse_pkg::PORT_RESET;
        station_addr = mrse_pkg::ADDR_RESET;
        end_ticks = mrse_pkg::GAP_RESET;
        served_reg = mrse_pkg::REGNUM_RESET;
        send_idle_pct = 23;
        take_idle_pct = 59;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: ticks while idle, a framing error, then read, write,
        // exception and dropped frames, each closed by a one-tick gap.
        write_reg(mrse_pkg::CFG_GAP_TICKS, 16'hFF01);
        add_item(1'b1, 8'hFF, 1'b1, 8'hFF);
        add_item(1'b0, 8'hFF, 1'b1, 8'h00);
        add_frame('{mrse_pkg::ADDR_RESET, mrse_pkg::FN_READ, 8'h00, 8'h01, 8'h00, 8'h01},
                  1, 1);
        pending_items[pending_items.size()-1].pin_state = 8'hA5;
        add_frame('{mrse_pkg::ADDR_RESET, mrse_pkg::FN_WRITE, 8'h00, 8'h01, 8'h00, 8'hFF},
                  1, 1);
        add_frame('{mrse_pkg::ADDR_RESET, mrse_pkg::FN_WRITE, 8'h00, 8'h01, 8'h01, 8'h00},
                  1, 1);
        add_frame('{mrse_pkg::ADDR_RESET, mrse_pkg::FN_WRITE, 8'h00, 8'h02, 8'h00, 8'h00},
                  1, 1);
        add_frame('{mrse_pkg::ADDR_RESET, 8'hFF, 8'h00, 8'h01}, 1, 1);
        add_frame('{mrse_pkg::ADDR_RESET, mrse_pkg::FN_READ, 8'h00, 8'h01, 8'h00, 8'h02},
                  1, 1);
        add_frame('{mrse_pkg::ADDR_RESET, mrse_pkg::FN_WRITE}, 1, 1);
        add_frame('{mrse_pkg::ADDR_RESET, 8'h00}, 0, 1);
        add_frame('{8'h21, mrse_pkg::FN_READ, 8'h00, 8'h01, 8'h00, 8'h01}, 1, 1);
        add_frame('{mrse_pkg::ADDR_RESET, mrse_pkg::FN_READ, 8'h00, 8'h01, 8'h00, 8'h01},
                  0, 1);
        f = {};
        for (int i = 0; i < 40; i++)
            f.push_back(8'($urandom));
        f[0] = mrse_pkg::ADDR_RESET;
        add_frame(f, 0, 1);
        drain();

        write_reg(mrse_pkg::CFG_SLAVE_ADDRESS, 16'h0000);
        write_reg(mrse_pkg::CFG_REGISTER_NUMBER, 16'hFFFF);
        write_reg(mrse_pkg::CFG_GAP_TICKS, 16'h0003);
        for (int n = 0; n < 4; n++)
            random_frame();
        drain();

        send_idle_pct = 59;
        take_idle_pct = 23;
        write_reg(mrse_pkg::CFG_SLAVE_ADDRESS, 16'h00FF);
        write_reg(mrse_pkg::CFG_REGISTER_NUMBER, 16'h0000);
        write_reg(mrse_pkg::CFG_GAP_TICKS, 16'h0002);
        for (int n = 0; n < 2; n++)
            random_frame();
        drain();

        send_idle_pct = 0;
        take_idle_pct = 0;
        write_reg(mrse_pkg::CFG_SLAVE_ADDRESS, 16'($urandom));
        write_reg(mrse_pkg::CFG_REGISTER_NUMBER, 16'($urandom));
        write_reg(mrse_pkg::CFG_GAP_TICKS, 16'h0004);
        random_frame();
        drain();
        write_reg(mrse_pkg::CFG_GAP_TICKS, 16'h0001);
        for (int n = 0; n < 2; n++)
            random_frame();
        drain();

        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > 400000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
